// File: hdl/sod_pkg.sv
// ----------------------------------------------------------------------------
// sod_pkg: shared constants and types of the sustained onset detector
// Field widths, register indexes and the structs passed between the top
// level and the frame core.
// ----------------------------------------------------------------------------
package sod_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int POSITION_BITS = 24;
   localparam int FRAME_BITS    = 12;

   localparam int FRAME_LENGTH_BITS = 13;
   localparam int ENERGY_BITS       = 42;
   localparam int SUSTAIN_BITS      = 10;
   localparam int WINDOW_BITS       = 24;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = ENERGY_BITS;

   // squared magnitude and the saturating accumulator
   localparam int SQ_BITS  = 2 * SAMPLE_BITS;
   localparam int SUM_BITS = ((SQ_BITS > ENERGY_BITS) ? SQ_BITS : ENERGY_BITS) + 1;

   // widths wide enough to compare a register against its saturation limit
   localparam int FL_WIDE  = (FRAME_LENGTH_BITS > FRAME_BITS + 1) ?
                             FRAME_LENGTH_BITS : FRAME_BITS + 1;
   localparam int WIN_WIDE = (WINDOW_BITS > POSITION_BITS) ? WINDOW_BITS : POSITION_BITS;

   localparam logic [FRAME_LENGTH_BITS-1:0] FRAME_LENGTH_RESET = 13'd441;
   localparam logic [ENERGY_BITS-1:0]       ENERGY_RESET       = 42'd47352014;
   localparam logic [SUSTAIN_BITS-1:0]      SUSTAIN_RESET      = 10'd8;
   localparam logic [WINDOW_BITS-1:0]       WINDOW_RESET       = 24'd1323000;

   localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = {ENERGY_BITS{1'b1}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_LENGTH     = 2'd0,
      CSR_ENERGY_THRESHOLD = 2'd1,
      CSR_SUSTAIN_FRAMES   = 2'd2,
      CSR_WINDOW_LENGTH    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [FRAME_LENGTH_BITS-1:0] frame_length;
      logic [ENERGY_BITS-1:0]       energy_threshold;
      logic [SUSTAIN_BITS-1:0]      sustain_frames;
      logic [WINDOW_BITS-1:0]       window_length;
   } cfg_type;

   typedef struct packed {
      logic [SQ_BITS-1:0] sq;
      logic               start;
      logic               last;
   } stage_type;

   typedef struct packed {
      logic                     done;
      logic                     found;
      logic [POSITION_BITS-1:0] position;
   } result_type;

endpackage

// File: hdl/sod_frame_core.sv
// ----------------------------------------------------------------------------
// sod_frame_core: frame energy accumulator and loud run tracker
// Holds the search state and works out, in one pass, the next state and any
// result for the registered request.
// ----------------------------------------------------------------------------
module sod_frame_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  sod_pkg::stage_type  item,
   input  sod_pkg::cfg_type    cfg,
   output sod_pkg::result_type res
);
   import sod_pkg::*;

   logic                     searching_ff, searching_in;
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [FRAME_BITS-1:0]    frame_fill_ff, frame_fill_in;
   logic [ENERGY_BITS-1:0]   frame_energy_ff, frame_energy_in;
   logic [SUSTAIN_BITS-1:0]  loud_run_ff, loud_run_in;
   logic [POSITION_BITS-1:0] run_start_ff, run_start_in;

   logic [FL_WIDE-1:0]       fl_raw, fl_max, fl_eff;
   logic [WIN_WIDE-1:0]      win_raw, pos_max;
   logic [POSITION_BITS-1:0] win_eff;
   logic [SUSTAIN_BITS-1:0]  sus_eff;

   logic                     srch;
   logic [POSITION_BITS-1:0] pos0, rs0, base, rs_new;
   logic [FRAME_BITS-1:0]    fill0;
   logic [ENERGY_BITS-1:0]   e0, e_sat;
   logic [SUSTAIN_BITS-1:0]  run0;
   logic [POSITION_BITS:0]   count;
   logic [FRAME_BITS:0]      fill1;
   logic [SUM_BITS-1:0]      sum;
   logic [SUSTAIN_BITS:0]    run1;
   logic                     in_win, frame_full, loud, hit, done;

   // saturate the registers to their usable ranges
   always_comb begin
      fl_raw  = FL_WIDE'(cfg.frame_length);
      fl_max  = FL_WIDE'(1) << FRAME_BITS;
      if (fl_raw == '0) begin
         fl_eff = FL_WIDE'(1);
      end else if (fl_raw > fl_max) begin
         fl_eff = fl_max;
      end else begin
         fl_eff = fl_raw;
      end
      win_raw = WIN_WIDE'(cfg.window_length);
      pos_max = WIN_WIDE'({POSITION_BITS{1'b1}});
      win_eff = (win_raw > pos_max) ? POSITION_BITS'(pos_max) : POSITION_BITS'(win_raw);
      sus_eff = (cfg.sustain_frames == '0) ? SUSTAIN_BITS'(1) : cfg.sustain_frames;
   end

   always_comb begin
      srch  = item.start | searching_ff;
      pos0  = item.start ? '0 : position_ff;
      fill0 = item.start ? '0 : frame_fill_ff;
      e0    = item.start ? '0 : frame_energy_ff;
      run0  = item.start ? '0 : loud_run_ff;
      rs0   = item.start ? '0 : run_start_ff;

      count  = {1'b0, pos0} + (POSITION_BITS+1)'(1);
      in_win = count <= {1'b0, win_eff};
      sum    = SUM_BITS'(e0) + SUM_BITS'(item.sq);
      e_sat  = (sum > SUM_BITS'(ENERGY_MAX)) ? ENERGY_MAX : sum[ENERGY_BITS-1:0];
      fill1  = {1'b0, fill0} + (FRAME_BITS+1)'(1);
      frame_full = in_win && (FL_WIDE'(fill1) >= fl_eff);
      loud   = e_sat > cfg.energy_threshold;
      base   = pos0 - POSITION_BITS'(fill0);
      run1   = {1'b0, run0} + (SUSTAIN_BITS+1)'(1);
      rs_new = (run0 == '0) ? base : rs0;
      hit    = srch && frame_full && loud && (run1 >= {1'b0, sus_eff});
      done   = srch && (hit || (count >= {1'b0, win_eff}) || item.last);

      res.done     = done;
      res.found    = hit;
      res.position = hit ? rs_new : '0;
   end

   always_comb begin
      searching_in    = searching_ff;
      position_in     = position_ff;
      frame_fill_in   = frame_fill_ff;
      frame_energy_in = frame_energy_ff;
      loud_run_in     = loud_run_ff;
      run_start_in    = run_start_ff;
      if (step) begin
         if (done) begin
            // drop the search once its result is out
            searching_in    = 1'b0;
            position_in     = '0;
            frame_fill_in   = '0;
            frame_energy_in = '0;
            loud_run_in     = '0;
            run_start_in    = '0;
         end else if (srch) begin
            searching_in    = 1'b1;
            position_in     = pos0;
            frame_fill_in   = fill0;
            frame_energy_in = e0;
            loud_run_in     = run0;
            run_start_in    = rs0;
            if (in_win) begin
               position_in = count[POSITION_BITS-1:0];
               if (frame_full) begin
                  frame_fill_in   = '0;
                  frame_energy_in = '0;
                  if (loud) begin
                     loud_run_in  = run1[SUSTAIN_BITS-1:0];
                     run_start_in = rs_new;
                  end else begin
                     loud_run_in  = '0;
                     run_start_in = '0;
                  end
               end else begin
                  frame_fill_in   = fill1[FRAME_BITS-1:0];
                  frame_energy_in = e_sat;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         searching_ff    <= 1'b0;
         position_ff     <= '0;
         frame_fill_ff   <= '0;
         frame_energy_ff <= '0;
         loud_run_ff     <= '0;
         run_start_ff    <= '0;
      end else begin
         searching_ff    <= searching_in;
         position_ff     <= position_in;
         frame_fill_ff   <= frame_fill_in;
         frame_energy_ff <= frame_energy_in;
         loud_run_ff     <= loud_run_in;
         run_start_ff    <= run_start_in;
      end
   end

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !searching_ff |-> (position_ff == '0 && frame_fill_ff == '0 &&
                         frame_energy_ff == '0 && loud_run_ff == '0))
      else $error("idle search state not cleared");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      loud_run_ff == '0 |-> run_start_ff == '0)
      else $error("run start held without a loud run");

   a_fill_le_pos: assert property (@(posedge clock) disable iff (reset)
      POSITION_BITS'(frame_fill_ff) <= position_ff)
      else $error("frame fill ahead of position");

   a_done_closes: assert property (@(posedge clock) disable iff (reset)
      step && res.done |=> !searching_ff)
      else $error("search still open after a result");

   a_no_spurious_open: assert property (@(posedge clock) disable iff (reset)
      step && !item.start && !searching_ff |=> !searching_ff)
      else $error("search opened without a start");

endmodule

// File: hdl/sustained_onset_detector.sv
// ----------------------------------------------------------------------------
// sustained_onset_detector: frame energy onset detector
// Searches an audio stream for a run of loud frames and reports where the
// run began, or that the window or the audio ended first.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one audio sample per request, with start_search opening a
//   new search at that sample (position zero) and last marking the end of
//   the audio. rsp_ channel: at most one result per search, found plus the
//   onset position relative to the search start (zero when not found).
//   csr_ channel: register writes, always ready; write only while no request
//   is in flight. A search may stay open across such writes.
//   Throughput: one request per cycle while no result is stalled on rsp_ready.
//   Each request passes an input register (holding the squared sample) and a
//   result register, so rsp_valid is registered. The rate is set by the
//   accumulate and compare on the frame state, which are combinational.
//   Reset: registers return to their defaults, no search is open and both
//   pipeline stages are empty.
//   Stall: while a result waits on rsp_ready, the input register holds and
//   req_ready drops once it is full; no request is lost.
// ----------------------------------------------------------------------------
module sustained_onset_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [sod_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                  req_start_search,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_found,
   output logic [sod_pkg::POSITION_BITS-1:0]     rsp_onset_position,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sod_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sod_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import sod_pkg::*;

   cfg_type                  cfg_ff, cfg_in;
   logic                     in_vld_ff, in_vld_in;
   stage_type                in_item_ff, in_item_in;
   logic                     rsp_vld_ff, rsp_vld_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [POSITION_BITS-1:0] rsp_pos_ff, rsp_pos_in;

   logic [SAMPLE_BITS-1:0]   mag;
   logic                     advance;
   result_type               res;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_LENGTH:     cfg_in.frame_length     = csr_data[FRAME_LENGTH_BITS-1:0];
            CSR_ENERGY_THRESHOLD: cfg_in.energy_threshold = csr_data[ENERGY_BITS-1:0];
            CSR_SUSTAIN_FRAMES:   cfg_in.sustain_frames   = csr_data[SUSTAIN_BITS-1:0];
            CSR_WINDOW_LENGTH:    cfg_in.window_length    = csr_data[WINDOW_BITS-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // square on the way in; the most negative sample maps to its magnitude
   always_comb begin
      mag = req_sample[SAMPLE_BITS-1] ? (~req_sample + SAMPLE_BITS'(1)) : req_sample;
   end

   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   always_comb begin
      in_item_in = in_item_ff;
      if (req_valid && req_ready) begin
         in_vld_in        = 1'b1;
         in_item_in.sq    = SQ_BITS'(mag) * SQ_BITS'(mag);
         in_item_in.start = req_start_search;
         in_item_in.last  = req_last;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   always_comb begin
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      if (advance) begin
         rsp_vld_in = res.done;
         if (res.done) begin
            rsp_found_in = res.found;
            rsp_pos_in   = res.position;
         end
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   sod_frame_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_item_ff),
      .cfg   (cfg_ff),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_length     <= FRAME_LENGTH_RESET;
         cfg_ff.energy_threshold <= ENERGY_RESET;
         cfg_ff.sustain_frames   <= SUSTAIN_RESET;
         cfg_ff.window_length    <= WINDOW_RESET;
         in_vld_ff               <= 1'b0;
         rsp_vld_ff              <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff   <= in_item_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_onset_position = rsp_pos_ff;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sustained onset detector
// Streams audio searches through the request channel under several register
// settings and flow patterns, predicts each onset result from a local copy
// of the frame state and checks every response against it in order.
// ----------------------------------------------------------------------------
module testbench;
   import sod_pkg::*;

   localparam int RESULT_LATENCY = 2;
   localparam int DRAIN_LIMIT    = 50000;
   localparam int TIMEOUT_NS     = 2000000;

   typedef enum int {
      FLOW_STEADY,
      FLOW_SENDER_GAPS,
      FLOW_RECEIVER_STALLS,
      FLOW_BOTH
   } flow_mode_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          start_search;
      logic                          last;
   } audio_request_type;

   typedef struct {
      logic                     found;
      logic [POSITION_BITS-1:0] position;
   } onset_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          req_start_search = 1'b0;
   logic                          req_last = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_found;
   logic [POSITION_BITS-1:0]      rsp_onset_position;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   csr_index_type                 csr_index = CSR_FRAME_LENGTH;
   logic [CSR_DATA_BITS-1:0]      csr_data = '0;

   audio_request_type sample_queue[$];
   onset_result_type  onset_expected[$];
   int                requests_queued = 0;
   int                requests_taken = 0;
   int                failures = 0;
   int                gap_pct = 0;
   int                stall_pct = 0;
   logic              req_fire = 1'b0;

   // local copy of the registers
   logic [FRAME_LENGTH_BITS-1:0] cfg_frame_length = FRAME_LENGTH_RESET;
   logic [ENERGY_BITS-1:0]       cfg_threshold    = ENERGY_RESET;
   logic [SUSTAIN_BITS-1:0]      cfg_sustain      = SUSTAIN_RESET;
   logic [WINDOW_BITS-1:0]       cfg_window       = WINDOW_RESET;

   // local copy of the search state
   bit                       search_open = 1'b0;
   logic [POSITION_BITS-1:0] search_pos  = '0;
   logic [FRAME_BITS-1:0]    frame_count = '0;
   logic [ENERGY_BITS-1:0]   frame_sum   = '0;
   logic [SUSTAIN_BITS-1:0]  loud_frames = '0;
   logic [POSITION_BITS-1:0] run_origin  = '0;

   sustained_onset_detector uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_start_search   (req_start_search),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_onset_position (rsp_onset_position),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #4 clock = ~clock;

   function automatic void clear_search_state();
      search_pos  = '0;
      frame_count = '0;
      frame_sum   = '0;
      loud_frames = '0;
      run_origin  = '0;
   endfunction

   // Advance the search by one sample; returns 1 when a result is due.
   function automatic bit search_step(input logic signed [SAMPLE_BITS-1:0] s,
                                      input logic start, input logic fin,
                                      output logic found,
                                      output logic [POSITION_BITS-1:0] onset);
      logic [FRAME_LENGTH_BITS-1:0] fl;
      logic [SUSTAIN_BITS-1:0]      sus;
      logic [POSITION_BITS:0]       count;
      logic [POSITION_BITS-1:0]     base;
      logic [SAMPLE_BITS:0]         mag;
      logic [ENERGY_BITS+1:0]       sum;
      logic [FRAME_BITS:0]          fill;
      logic [SUSTAIN_BITS:0]        run;
      bit                           hit;
      bit                           done;
      found = 1'b0;
      onset = '0;
      hit   = 1'b0;
      done  = 1'b0;
      if (start) begin
         search_open = 1'b1;
         clear_search_state();
      end
      if (!search_open) return 1'b0;
      fl = (cfg_frame_length == '0) ? FRAME_LENGTH_BITS'(1) : cfg_frame_length;
      if (fl > FRAME_LENGTH_BITS'(1 << FRAME_BITS)) fl = FRAME_LENGTH_BITS'(1 << FRAME_BITS);
      sus = (cfg_sustain == '0) ? SUSTAIN_BITS'(1) : cfg_sustain;
      count = {1'b0, search_pos} + 1'b1;
      if (count <= {1'b0, cfg_window}) begin
         base = search_pos - POSITION_BITS'(frame_count);
         mag  = s[SAMPLE_BITS-1] ? -{s[SAMPLE_BITS-1], s} : {1'b0, s};
         sum  = frame_sum + mag * mag;
         frame_sum = (sum > ENERGY_MAX) ? ENERGY_MAX : sum[ENERGY_BITS-1:0];
         fill = frame_count + 1'b1;
         search_pos = count[POSITION_BITS-1:0];
         if (fill >= fl) begin
            if (frame_sum > cfg_threshold) begin
               if (loud_frames == 0) run_origin = base;
               run = loud_frames + 1'b1;
               if (run >= sus) hit = 1'b1;
               loud_frames = run[SUSTAIN_BITS-1:0];
            end else begin
               loud_frames = '0;
               run_origin  = '0;
            end
            fill = '0;
            frame_sum = '0;
         end
         frame_count = fill[FRAME_BITS-1:0];
      end
      if (hit) begin
         found = 1'b1;
         onset = run_origin;
         done  = 1'b1;
      end else if (count >= {1'b0, cfg_window} || fin) begin
         done = 1'b1;
      end
      if (done) begin
         search_open = 1'b0;
         clear_search_state();
      end
      return done;
   endfunction

   // Present the next request once the current one is taken.
   always @(negedge clock) begin : drive_requests
      audio_request_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (sample_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
            item = sample_queue.pop_front();
            req_valid        <= 1'b1;
            req_sample       <= item.sample;
            req_start_search <= item.start_search;
            req_last         <= item.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : watch_ports
      onset_result_type want;
      onset_result_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (onset_expected.size() == 0) begin
               if (failures < 10)
                  $display("unexpected result: found=%0b position=%0d",
                           rsp_found, rsp_onset_position);
               failures++;
            end else begin
               want = onset_expected.pop_front();
               if (rsp_found !== want.found || rsp_onset_position !== want.position) begin
                  if (failures < 10)
                     $display({"mismatch: expected found=%0b position=%0d,",
                               " got found=%0b position=%0d"},
                              want.found, want.position, rsp_found, rsp_onset_position);
                  failures++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_LENGTH:     cfg_frame_length = csr_data[FRAME_LENGTH_BITS-1:0];
               CSR_ENERGY_THRESHOLD: cfg_threshold    = csr_data[ENERGY_BITS-1:0];
               CSR_SUSTAIN_FRAMES:   cfg_sustain      = csr_data[SUSTAIN_BITS-1:0];
               CSR_WINDOW_LENGTH:    cfg_window       = csr_data[WINDOW_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            requests_taken++;
            if (search_step(req_sample, req_start_search, req_last, got.found, got.position))
               onset_expected.insert(onset_expected.size(), got);
         end
      end
      req_fire <= !reset && req_valid && req_ready;
   end

   function automatic void set_flow(flow_mode_type mode);
      case (mode)
         FLOW_SENDER_GAPS:     begin gap_pct = 47; stall_pct = 0;  end
         FLOW_RECEIVER_STALLS: begin gap_pct = 0;  stall_pct = 47; end
         FLOW_BOTH:            begin gap_pct = 24; stall_pct = 24; end
         default:              begin gap_pct = 0;  stall_pct = 0;  end
      endcase
   endfunction

   function automatic void queue_sample(logic signed [SAMPLE_BITS-1:0] s, logic start,
                                        logic fin);
      audio_request_type req;
      req.sample       = s;
      req.start_search = start;
      req.last         = fin;
      sample_queue.insert(sample_queue.size(), req);
      requests_queued++;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(bit loud);
      int mag;
      if ($urandom_range(19) == 0) return SAMPLE_BITS'($urandom);
      mag = loud ? $urandom_range(32767, 12000) : $urandom_range(1500, 0);
      if ($urandom_range(1)) return SAMPLE_BITS'(-mag);
      return SAMPLE_BITS'(mag);
   endfunction

   // Scatter random bits above the register width; the block must drop them.
   task automatic write_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value,
                                 int width);
      logic [CSR_DATA_BITS-1:0] keep;
      keep = (width >= CSR_DATA_BITS) ? '1 : ((CSR_DATA_BITS'(1) << width) - 1'b1);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= (value & keep) | (CSR_DATA_BITS'({$urandom, $urandom}) & ~keep);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_settings(int unsigned fl, longint unsigned thr, int unsigned sus,
                                int unsigned win);
      write_register(CSR_FRAME_LENGTH, CSR_DATA_BITS'(fl), FRAME_LENGTH_BITS);
      write_register(CSR_ENERGY_THRESHOLD, CSR_DATA_BITS'(thr), ENERGY_BITS);
      write_register(CSR_SUSTAIN_FRAMES, CSR_DATA_BITS'(sus), SUSTAIN_BITS);
      write_register(CSR_WINDOW_LENGTH, CSR_DATA_BITS'(win), WINDOW_BITS);
   endtask

   // Wait for every request and result, then let the pipeline empty.
   task automatic drain_requests();
      int waited;
      waited = 0;
      while ((requests_taken != requests_queued || onset_expected.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (RESULT_LATENCY + 6) @(negedge clock);
   endtask

   // One search: aligned frames, each mostly loud or mostly quiet.
   task automatic queue_search(int fl);
      int frames;
      int end_at;
      int n;
      int f;
      int k;
      bit loud;
      frames = $urandom_range(12, 1);
      end_at = ($urandom_range(3) == 0) ? $urandom_range(frames * fl - 1) : -1;
      n = 0;
      for (f = 0; f < frames; f++) begin
         loud = $urandom_range(99) < 65;
         for (k = 0; k < fl; k++) begin
            queue_sample(pick_sample(loud), n == 0, n == end_at);
            n++;
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      int fl;
      int sus;
      int win;
      int mark;
      int k;
      longint unsigned thr;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_flow(FLOW_STEADY);

      // idle sample with no search open
      queue_sample(16'sd32767, 1'b0, 1'b1);
      drain_requests();

      // quiet frame then two loud ones; trailing samples are ignored
      load_settings(2, 0, 2, 100);
      queue_sample(0, 1'b1, 1'b0);
      queue_sample(0, 1'b0, 1'b0);
      queue_sample(5, 1'b0, 1'b0);
      queue_sample(5, 1'b0, 1'b0);
      queue_sample(-7, 1'b0, 1'b0);
      queue_sample(7, 1'b0, 1'b0);
      queue_sample(3, 1'b0, 1'b0);
      queue_sample(0, 1'b0, 1'b1);
      // restart in the middle of a search
      queue_sample(1000, 1'b1, 1'b0);
      queue_sample(1000, 1'b0, 1'b0);
      queue_sample(0, 1'b1, 1'b0);
      queue_sample(0, 1'b0, 1'b0);
      queue_sample(9, 1'b0, 1'b0);
      queue_sample(9, 1'b0, 1'b0);
      queue_sample(9, 1'b0, 1'b0);
      queue_sample(9, 1'b0, 1'b0);
      drain_requests();

      set_flow(FLOW_BOTH);
      // zero window ends the search on its start sample
      load_settings(1, ENERGY_MAX, 1023, 0);
      queue_sample(16'sd32767, 1'b1, 1'b0);
      drain_requests();

      // zero frame length and sustain; energy equal to the limit is not loud
      load_settings(0, 32767 * 32767, 0, 24'hFFFFFF);
      queue_sample(16'sd32767, 1'b1, 1'b0);
      queue_sample(-16'sd32768, 1'b0, 1'b0);
      drain_requests();

      // partial frame dropped on the last sample
      load_settings(4, 0, 1023, 100);
      queue_sample(1, 1'b1, 1'b0);
      queue_sample(1, 1'b0, 1'b0);
      queue_sample(1, 1'b0, 1'b1);
      drain_requests();

      // onset on the last sample and on the window's final sample
      load_settings(1, 0, 1, 2);
      queue_sample(1, 1'b1, 1'b1);
      queue_sample(0, 1'b1, 1'b0);
      queue_sample(1, 1'b0, 1'b0);
      drain_requests();

      // oversized frame length; the audio ends inside the first frame
      set_flow(FLOW_SENDER_GAPS);
      load_settings(8191, ENERGY_MAX - 1, 1, 24'hFFFFFF);
      for (k = 0; k < 16; k++)
         queue_sample(-16'sd32768, k == 0, k == 15);
      drain_requests();

      for (phase = 0; phase < 8; phase++) begin
         set_flow(flow_mode_type'(phase % 4));
         fl  = (phase == 0 || phase == 3) ? 1 : $urandom_range(6, 2);
         sus = (phase == 1) ? 1 : $urandom_range(4, 1);
         case (phase)
            2:       win = 24'hFFFFFF;
            3:       win = 1;
            default: win = $urandom_range(80, 8);
         endcase
         thr = (phase == 4) ? 0 : longint'(fl) * $urandom_range(1 << 26, 1 << 22);
         load_settings(fl, thr, sus, win);
         mark = requests_queued;
         while (requests_queued - mark < 75) begin
            if ($urandom_range(9) == 0) begin
               // stray samples outside the search framing
               repeat ($urandom_range(4, 1))
                  queue_sample(SAMPLE_BITS'($urandom), 1'b0, $urandom_range(3) == 0);
            end else begin
               queue_search(fl);
            end
         end
         drain_requests();
      end

      if (requests_taken != requests_queued) begin
         $display("%0d requests never taken", requests_queued - requests_taken);
         failures++;
      end
      if (onset_expected.size() != 0) begin
         $display("%0d expected results never arrived", onset_expected.size());
         failures += onset_expected.size();
      end
      if (failures == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("testbench NOT OK");
      $finish;
   end

endmodule
